### rtl/core/uri_split_pkg.sv
// ============================================================================
// URI splitter package
// Length limit, derived widths, parser phases and character class helpers.
// ============================================================================
package uri_split_pkg;

    // Longest string that is parsed; later bytes only raise the overflow flag
    localparam int MAX_LEN = 4096;

    // Position counter holds 0 .. MAX_LEN
    localparam int POS_W = $clog2(MAX_LEN + 1);

    // Result field widths
    localparam int COLON_W = 12;
    localparam int OFS_W   = 13;
    localparam int OUT_W   = 72;

    // Characters of interest
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_HASH  = 8'h23;

    // Parser phases
    typedef enum logic [2:0] {
        PH_FIRST,
        PH_SCHEME,
        PH_SLASH1,
        PH_SLASH2,
        PH_AUTH,
        PH_PATH,
        PH_QUERY,
        PH_DONE
    } t_phase;

    // ASCII letter
    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    // Letter, digit, plus, minus or dot
    function automatic logic is_scheme_char(input logic [7:0] b);
        return is_letter(b) || ((b >= 8'h30) && (b <= 8'h39)) ||
               (b == CH_PLUS) || (b == CH_MINUS) || (b == CH_DOT);
    endfunction

endpackage

### rtl/core/uri_component_splitter.sv
// The result item becomes valid in the cycle after the item marked last is taken.
// One byte item is taken per cycle, also across string borders, while the result output is not held back.
// The parser state and offsets update in the cycle a byte is taken; one output
// register holds the result, and while it waits untaken the byte input stalls.
// Reset (i_rst_n low, synchronous) clears the parser state and drops any
// pending result.
// ============================================================================
// URI component splitter
// Scans a URI byte stream and reports scheme, path, query and fragment
// offsets, the length and the relative, hierarchical and overflow flags.
// ============================================================================
module uri_component_splitter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Byte input
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // byte_in
    input  logic                          s_axis_tlast,   // is_last
    // Result output
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // relative[0], scheme_colon[12:1], path_start[25:13], query_start[38:26],
    // fragment_start[51:39], total_length[64:52], hierarchical[65],
    // too_long[66], zero[71:67]
    output logic [uri_split_pkg::OUT_W-1:0] m_axis_tdata
);

    localparam int PW = uri_split_pkg::POS_W;
    localparam logic [PW-1:0] LIMIT = PW'(uri_split_pkg::MAX_LEN);

    // Parser state
    uri_split_pkg::t_phase r_phase, n_phase;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_colon, n_colon;
    logic [PW-1:0] r_path, n_path;
    logic [PW-1:0] r_query, n_query;
    logic [PW-1:0] r_frag, n_frag;
    logic          r_rel, n_rel;
    logic          r_auth, n_auth;
    logic          r_ovf, n_ovf;

    // Output register
    logic                           r_out_valid;
    logic [uri_split_pkg::OUT_W-1:0] r_out_data, n_out_data;

    logic accept;
    logic scan;
    logic [7:0] b;

    // Closed-out offsets for the result
    logic          fin_rel;
    logic [PW-1:0] fin_colon;
    logic [PW-1:0] fin_path;
    logic [PW-1:0] fin_query;
    logic [PW-1:0] fin_frag;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Parse one byte, then close the string on the last byte
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_colon = r_colon;
        n_path  = r_path;
        n_query = r_query;
        n_frag  = r_frag;
        n_rel   = r_rel;
        n_auth  = r_auth;
        n_ovf   = r_ovf;
        scan    = 1'b0;

        if (r_pos < LIMIT) begin
            n_pos = r_pos + PW'(1);
            // Phase step
            unique case (r_phase)
                uri_split_pkg::PH_FIRST: begin
                    if (uri_split_pkg::is_letter(b)) begin
                        n_phase = uri_split_pkg::PH_SCHEME;
                    end else begin
                        n_rel   = 1'b1;
                        n_colon = '0;
                        n_path  = '0;
                        n_phase = uri_split_pkg::PH_PATH;
                        scan    = 1'b1;
                    end
                end
                uri_split_pkg::PH_SCHEME: begin
                    if (b == uri_split_pkg::CH_COLON) begin
                        n_colon = r_pos;
                        n_path  = r_pos + PW'(1);
                        n_phase = uri_split_pkg::PH_SLASH1;
                    end else if (!uri_split_pkg::is_scheme_char(b)) begin
                        n_rel   = 1'b1;
                        n_colon = '0;
                        n_path  = '0;
                        n_phase = uri_split_pkg::PH_PATH;
                        scan    = 1'b1;
                    end
                end
                uri_split_pkg::PH_SLASH1: begin
                    if (b == uri_split_pkg::CH_SLASH) begin
                        n_phase = uri_split_pkg::PH_SLASH2;
                    end else begin
                        n_phase = uri_split_pkg::PH_PATH;
                        scan    = 1'b1;
                    end
                end
                uri_split_pkg::PH_SLASH2: begin
                    if (b == uri_split_pkg::CH_SLASH) begin
                        n_auth  = 1'b1;
                        n_phase = uri_split_pkg::PH_AUTH;
                    end else begin
                        n_phase = uri_split_pkg::PH_PATH;
                        scan    = 1'b1;
                    end
                end
                uri_split_pkg::PH_AUTH: begin
                    if ((b == uri_split_pkg::CH_SLASH) || (b == uri_split_pkg::CH_QMARK) ||
                        (b == uri_split_pkg::CH_HASH)) begin
                        n_path  = r_pos;
                        n_phase = uri_split_pkg::PH_PATH;
                        scan    = 1'b1;
                    end
                end
                default: begin
                    scan = 1'b1;
                end
            endcase

            // Query and fragment marks
            if (scan) begin
                if (n_phase == uri_split_pkg::PH_PATH) begin
                    if (b == uri_split_pkg::CH_HASH) begin
                        n_query = r_pos;
                        n_frag  = r_pos;
                        n_phase = uri_split_pkg::PH_DONE;
                    end else if (b == uri_split_pkg::CH_QMARK) begin
                        n_query = r_pos;
                        n_phase = uri_split_pkg::PH_QUERY;
                    end
                end else if (n_phase == uri_split_pkg::PH_QUERY) begin
                    if (b == uri_split_pkg::CH_HASH) begin
                        n_frag  = r_pos;
                        n_phase = uri_split_pkg::PH_DONE;
                    end
                end
            end
        end else begin
            n_ovf = 1'b1;
        end

        // Fill in absent components with the length, for the result only
        fin_rel   = n_rel;
        fin_colon = n_colon;
        fin_path  = n_path;
        fin_query = n_query;
        fin_frag  = n_frag;
        unique case (n_phase)
            uri_split_pkg::PH_FIRST, uri_split_pkg::PH_SCHEME: begin
                fin_rel   = 1'b1;
                fin_colon = '0;
                fin_path  = '0;
                fin_query = n_pos;
                fin_frag  = n_pos;
            end
            uri_split_pkg::PH_SLASH1, uri_split_pkg::PH_SLASH2,
            uri_split_pkg::PH_PATH: begin
                fin_query = n_pos;
                fin_frag  = n_pos;
            end
            uri_split_pkg::PH_AUTH: begin
                fin_path  = n_pos;
                fin_query = n_pos;
                fin_frag  = n_pos;
            end
            uri_split_pkg::PH_QUERY: begin
                fin_frag  = n_pos;
            end
            default: begin
            end
        endcase

        // Pack the result
        n_out_data        = '0;
        n_out_data[0]     = fin_rel;
        n_out_data[12:1]  = fin_rel ? '0 : uri_split_pkg::COLON_W'(fin_colon);
        n_out_data[25:13] = uri_split_pkg::OFS_W'(fin_path);
        n_out_data[38:26] = uri_split_pkg::OFS_W'(fin_query);
        n_out_data[51:39] = uri_split_pkg::OFS_W'(fin_frag);
        n_out_data[64:52] = uri_split_pkg::OFS_W'(n_pos);
        n_out_data[65]    = fin_rel || n_auth;
        n_out_data[66]    = n_ovf;
    end

    // Parser state: advance on each byte, restart after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= uri_split_pkg::PH_FIRST;
            r_pos   <= '0;
            r_colon <= '0;
            r_path  <= '0;
            r_query <= '0;
            r_frag  <= '0;
            r_rel   <= 1'b0;
            r_auth  <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (accept) begin
            if (s_axis_tlast) begin
                r_phase <= uri_split_pkg::PH_FIRST;
                r_pos   <= '0;
                r_colon <= '0;
                r_path  <= '0;
                r_query <= '0;
                r_frag  <= '0;
                r_rel   <= 1'b0;
                r_auth  <= 1'b0;
                r_ovf   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_colon <= n_colon;
                r_path  <= n_path;
                r_query <= n_query;
                r_frag  <= n_frag;
                r_rel   <= n_rel;
                r_auth  <= n_auth;
                r_ovf   <= n_ovf;
            end
        end
    end

    // Output valid: set on the last byte, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && s_axis_tlast) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload: load with the finished string
    always_ff @(posedge i_clk) begin
        if (accept && s_axis_tlast) begin
            r_out_data <= n_out_data;
        end
    end

endmodule
